[src/tar_stream_deframer_unit_macros.svh]
// Assertion macros shared by the checkers of the tar stream deframer.
// Depends on nothing; included by the checker file only.
`ifndef TAR_STREAM_DEFRAMER_UNIT_MACROS_SVH
`define TAR_STREAM_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tsd_pkg.sv]
// Shared types and constants of the tar stream deframer.
// Depends on nothing; imported by every module of the block.
package tsd_pkg;

  localparam int BLOCK_BYTES        = 512;
  localparam int OFF_W              = $clog2(BLOCK_BYTES);
  localparam int NAME_BYTES         = 100;
  localparam int SIZE_OFFSET        = 124;
  localparam int MTIME_OFFSET       = 136;
  localparam int DEF_OCTAL_DIGITS   = 12;
  localparam int ACC_W              = 36;
  localparam int BYTE_W             = 8;
  localparam int KIND_W             = 2;
  localparam int OUT_TDATA_W        = 80;

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

  typedef enum logic [KIND_W-1:0] {
    KIND_NAME   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_END    = 2'd3
  } tsd_kind_t;

  typedef struct packed {
    tsd_kind_t          kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [ACC_W-1:0]   entry_size;
    logic [ACC_W-1:0]   entry_mtime;
    logic               last_data;
  } tsd_result_t;

endpackage

[src/tsd_octal_field.sv]
// Accumulator for one octal header field (size or mtime) of the deframer.
// Depends on tsd_pkg.
module tsd_octal_field
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              feed,
  input  logic              clear,
  input  logic [BYTE_W-1:0] char_in,
  output logic [ACC_W-1:0]  value
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             stopped_r, stopped_nxt;
  logic             is_digit;
  logic             is_term;

  assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_SEVEN);
  assign is_term  = (char_in == CHAR_SPACE) || (char_in == CHAR_NUL);

  always_comb begin
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    if (clear) begin
      acc_nxt     = '0;
      stopped_nxt = 1'b0;
    end else if (feed && !stopped_r) begin
      // A terminator only ends the field once some digit made it nonzero.
      if (is_digit) begin
        acc_nxt = {acc_r[ACC_W-4:0], char_in[2:0]};
      end else if (is_term && (acc_r != '0)) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  assign value = acc_r;

endmodule

[src/tsd_parser.sv]
// Block-level parse state of the tar stream deframer: phase, offsets, counters.
// Depends on tsd_pkg and tsd_octal_field.
module tsd_parser
  import tsd_pkg::*;
#(
  parameter int OCTAL_FIELD_DIGITS = DEF_OCTAL_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] char_in,
  output logic              emit,
  output tsd_result_t       result
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } tsd_phase_t;

  localparam logic [OFF_W-1:0] LAST_OFF   = OFF_W'(BLOCK_BYTES - 1);
  localparam logic [OFF_W-1:0] NAME_END   = OFF_W'(NAME_BYTES);
  localparam logic [OFF_W-1:0] SIZE_BEG   = OFF_W'(SIZE_OFFSET);
  localparam logic [OFF_W-1:0] SIZE_END   = OFF_W'(SIZE_OFFSET + OCTAL_FIELD_DIGITS);
  localparam logic [OFF_W-1:0] MTIME_BEG  = OFF_W'(MTIME_OFFSET);
  localparam logic [OFF_W-1:0] MTIME_END  = OFF_W'(MTIME_OFFSET + OCTAL_FIELD_DIGITS);

  tsd_phase_t       phase_r, phase_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic             name_done_r, name_done_nxt;
  logic             all_zero_r, all_zero_nxt;
  logic [ACC_W-1:0] data_left_r, data_left_nxt;
  logic [OFF_W-1:0] pad_left_r, pad_left_nxt;
  logic [ACC_W-1:0] size_val, mtime_val;
  logic             in_header;
  logic             size_feed, mtime_feed;
  logic             hdr_clear;

  assign in_header  = step && (phase_r == PH_HEADER);
  assign size_feed  = in_header && (offset_r >= SIZE_BEG) && (offset_r < SIZE_END);
  assign mtime_feed = in_header && (offset_r >= MTIME_BEG) && (offset_r < MTIME_END);
  assign hdr_clear  = in_header && (offset_r == LAST_OFF);

  tsd_octal_field u_size (
    .clk     (clk),
    .rst_n   (rst_n),
    .feed    (size_feed),
    .clear   (hdr_clear),
    .char_in (char_in),
    .value   (size_val)
  );

  tsd_octal_field u_mtime (
    .clk     (clk),
    .rst_n   (rst_n),
    .feed    (mtime_feed),
    .clear   (hdr_clear),
    .char_in (char_in),
    .value   (mtime_val)
  );

  always_comb begin
    phase_nxt     = phase_r;
    offset_nxt    = offset_r;
    name_done_nxt = name_done_r;
    all_zero_nxt  = all_zero_r;
    data_left_nxt = data_left_r;
    pad_left_nxt  = pad_left_r;
    emit          = 1'b0;
    result        = '{kind: KIND_NAME, byte_value: '0, entry_size: '0,
                      entry_mtime: '0, last_data: 1'b0};
    if (step) begin
      unique case (phase_r)
        PH_HEADER: begin
          all_zero_nxt = all_zero_r && (char_in == CHAR_NUL);
          if ((offset_r < NAME_END) && !name_done_r) begin
            if (char_in == CHAR_NUL) begin
              name_done_nxt = 1'b1;
            end else begin
              emit              = 1'b1;
              result.kind       = KIND_NAME;
              result.byte_value = char_in;
            end
          end
          if (offset_r == LAST_OFF) begin
            emit = 1'b1;
            if (all_zero_nxt) begin
              result.kind = KIND_END;
              phase_nxt   = PH_DONE;
            end else begin
              result.kind        = KIND_HEADER;
              result.entry_size  = size_val;
              result.entry_mtime = mtime_val;
              data_left_nxt      = size_val;
              pad_left_nxt       = OFF_W'(0) - size_val[OFF_W-1:0];
              phase_nxt          = (size_val != '0) ? PH_DATA : PH_HEADER;
            end
            offset_nxt    = '0;
            name_done_nxt = 1'b0;
            all_zero_nxt  = 1'b1;
          end else begin
            offset_nxt = offset_r + OFF_W'(1);
          end
        end
        PH_DATA: begin
          emit              = 1'b1;
          result.kind       = KIND_DATA;
          result.byte_value = char_in;
          result.last_data  = (data_left_r == ACC_W'(1));
          if (data_left_r != '0) begin
            data_left_nxt = data_left_r - ACC_W'(1);
          end
          if (data_left_nxt == '0) begin
            phase_nxt = (pad_left_r != '0) ? PH_PAD : PH_HEADER;
          end
        end
        PH_PAD: begin
          if (pad_left_r != '0) begin
            pad_left_nxt = pad_left_r - OFF_W'(1);
          end
          if (pad_left_nxt == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      offset_r    <= '0;
      name_done_r <= 1'b0;
      all_zero_r  <= 1'b1;
      data_left_r <= '0;
      pad_left_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      offset_r    <= offset_nxt;
      name_done_r <= name_done_nxt;
      all_zero_r  <= all_zero_nxt;
      data_left_r <= data_left_nxt;
      pad_left_r  <= pad_left_nxt;
    end
  end

endmodule

[src/tar_stream_deframer_unit.sv]
// Top level of the tar stream deframer: input register, parser, result register.
// Depends on tsd_pkg and tsd_parser.
//
// The deframer takes a ustar archive one byte per input beat and turns it into
// a stream of result beats: name bytes of each header (kind 0), one header
// record per entry with its parsed size and modification time (kind 1), the
// entry's data bytes with tlast on the final one (kind 2), and a single
// end-of-archive beat (kind 3) for the first all-zero header block, after
// which every input byte is taken and dropped. Padding to the 512-byte block
// boundary and header bytes other than the name are consumed silently. The
// block accepts one byte per clock cycle, sustained, with no bubbles while the
// result side does not stall: a byte is held in the input register, is parsed
// by the short logic behind it, and the result it yields, if any, lands in the
// result register. The only stall is back-pressure on the result side, which
// reaches in_tready through the input register in the same cycle.
// Checksums are not verified and a truncated archive is not detected.
module tar_stream_deframer_unit
  import tsd_pkg::*;
#(
  parameter int OCTAL_FIELD_DIGITS = DEF_OCTAL_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] in_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] byte_value, [43:8] entry_size,
                                             // [79:44] entry_mtime
  output logic [KIND_W-1:0]      out_tuser,  // [1:0] kind
  output logic                   out_tlast   // last_data
);

  // Input register: holds one accepted byte until the parser can take it.
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              advance;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  tsd_result_t       out_res_r;

  logic              emit;
  tsd_result_t       result;

  // The held byte moves on whenever the result register is free or is being
  // drained in this cycle; a byte that produces no result moves on as well.
  assign advance      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !in_valid_r || advance;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !advance);

  tsd_parser #(
    .OCTAL_FIELD_DIGITS (OCTAL_FIELD_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .char_in (in_byte_r),
    .emit    (emit),
    .result  (result)
  );

  assign out_valid_nxt = advance ? emit : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance && emit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.entry_mtime, out_res_r.entry_size, out_res_r.byte_value};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last_data;

endmodule

[src/tsd_checker.sv]
// Port-level checker for the tar stream deframer, bound to its top level.
// Depends on tsd_pkg and tar_stream_deframer_unit_macros.svh.
`include "tar_stream_deframer_unit_macros.svh"

module tsd_checker
  import tsd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]      out_tuser,
  input logic                   out_tlast
);

  `TSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed while stalled")
  `TSD_ASSERT_IMPLY(a_last_only_data, clk, rst_n, out_tvalid && out_tlast, out_tuser == KIND_DATA, "tlast on a beat that is not a data byte")
  `TSD_ASSERT_IMPLY(a_fields_zero, clk, rst_n, out_tvalid && (out_tuser != KIND_HEADER), out_tdata[OUT_TDATA_W-1:BYTE_W] == '0, "size or mtime set outside a header record")
  `TSD_ASSERT_NEXT(a_quiet_after_end, clk, rst_n, out_tvalid && out_tready && (out_tuser == KIND_END), !out_tvalid, "result after end of archive")

endmodule

bind tar_stream_deframer_unit tsd_checker u_tsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
